[src/tmlm_pkg.sv]
// Shared types, codes and constants of the track majority label matcher.
package tmlm_pkg;

    // Fixed field widths of the transaction payloads
    localparam int PARTICLE_LABEL_W = 24;
    localparam int BEST_LABEL_W     = 25;
    localparam int TALLY_W          = 8;
    localparam int DISTINCT_W       = 7;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LABELS = 64;
    localparam int DEF_COUNT_BITS = 8;
    localparam int DEF_LABEL_BITS = 24;

    // Input codes
    localparam logic       ACTION_HIT = 1'b0;
    localparam logic       ACTION_END = 1'b1;
    localparam logic [1:0] KIND_LABEL = 2'd0;
    localparam logic [1:0] KIND_FAKE  = 2'd1;

    // Output constants
    localparam logic [TALLY_W-1:0]           TALLY_MAX    = '1;
    localparam logic [DISTINCT_W-1:0]        DISTINCT_MAX = '1;
    localparam logic signed [BEST_LABEL_W-1:0] NO_LABEL   = -25'sd1;

    typedef struct packed {
        logic                        action;
        logic [1:0]                  hit_kind;
        logic [PARTICLE_LABEL_W-1:0] particle_label;
    } hit_t;

    typedef struct packed {
        logic signed [BEST_LABEL_W-1:0] best_label;
        logic [TALLY_W-1:0]             true_hits;
        logic [TALLY_W-1:0]             wrong_hits;
        logic [TALLY_W-1:0]             fake_hits;
        logic [DISTINCT_W-1:0]          distinct_labels;
        logic                           label_overflow;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the accepted hit
        logic fake_inc;    // count one fake hit
        logic scan_start;  // rewind the table walk and the winner search
        logic rd_issue;    // read the next table entry, if any is left
        logic accumulate;  // fold the returned entry into the winner search
        logic hit_write;   // bump the count of the matched entry
        logic miss_write;  // append a new label, or flag overflow
        logic emit;        // present the result and clear the track
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic match;     // returned entry holds the current label
        logic scan_end;  // every entry read and returned
    } ctrl_status_t;

endpackage

[src/tmlm_ctrl.sv]
// Sequencer of the track majority label matcher: accepts transactions, walks the table.
module tmlm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tmlm_pkg::hit_t        hit,
    input  tmlm_pkg::ctrl_status_t status,
    output tmlm_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HSCAN = 2'd1;
    localparam logic [1:0] ST_ESCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (hit.action == tmlm_pkg::ACTION_END)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_ESCAN;
                    end
                    else if (hit.hit_kind == tmlm_pkg::KIND_LABEL)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_HSCAN;
                    end
                    else if (hit.hit_kind == tmlm_pkg::KIND_FAKE)
                    begin
                        cmd.fake_inc = 1'b1;
                    end
                end
            end
            ST_HSCAN:
            begin
                if (status.match)
                begin
                    cmd.hit_write = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.scan_end)
                begin
                    cmd.miss_write = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            ST_ESCAN:
            begin
                cmd.accumulate = 1'b1;
                if (status.scan_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[src/tmlm_datapath.sv]
// Label table, track tallies, winner search and result register of the matcher.
module tmlm_datapath
#(
    parameter int MAX_LABELS = tmlm_pkg::DEF_MAX_LABELS,
    parameter int COUNT_BITS = tmlm_pkg::DEF_COUNT_BITS,
    parameter int LABEL_BITS = tmlm_pkg::DEF_LABEL_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmlm_pkg::hit_t         hit,
    input  tmlm_pkg::ctrl_cmd_t    cmd,
    output tmlm_pkg::ctrl_status_t status,
    output logic                   done,
    output tmlm_pkg::result_t      result
);

    localparam int IDX_W  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CNT_W  = $clog2(MAX_LABELS + 1);
    localparam int TOT_W  = COUNT_BITS + IDX_W + 9;
    localparam int PEXT_W = (LABEL_BITS > tmlm_pkg::PARTICLE_LABEL_W) ?
                            LABEL_BITS : tmlm_pkg::PARTICLE_LABEL_W;
    localparam int LEXT_W = (LABEL_BITS > tmlm_pkg::BEST_LABEL_W) ?
                            LABEL_BITS : tmlm_pkg::BEST_LABEL_W;
    localparam int CEXT_W = (COUNT_BITS > tmlm_pkg::TALLY_W) ?
                            COUNT_BITS : tmlm_pkg::TALLY_W;
    localparam int DEXT_W = (CNT_W > tmlm_pkg::DISTINCT_W) ? CNT_W : tmlm_pkg::DISTINCT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Table storage
    logic [LABEL_BITS-1:0] label_mem [MAX_LABELS];
    logic [COUNT_BITS-1:0] count_mem [MAX_LABELS];

    // Track state
    logic [LABEL_BITS-1:0]       label_reg;
    logic [CNT_W-1:0]            used_reg;
    logic [tmlm_pkg::TALLY_W-1:0] fake_reg;
    logic [tmlm_pkg::TALLY_W-1:0] drop_reg;
    logic                        ovf_reg;

    // Table walk
    logic [CNT_W-1:0]      idx_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [LABEL_BITS-1:0] rd_label_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;

    // Winner search
    logic                  found_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [LABEL_BITS-1:0] best_lab_reg;
    logic [TOT_W-1:0]      total_reg;

    logic                  done_reg;
    tmlm_pkg::result_t     result_reg;
    tmlm_pkg::result_t     result_next;

    logic                  full;
    logic                  rd_fire;
    logic                  acc_fire;
    logic                  take;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_count;
    logic [PEXT_W-1:0]     pl_ext;
    logic [LEXT_W-1:0]     lab_ext;
    logic [CEXT_W-1:0]     cnt_ext;
    logic [DEXT_W-1:0]     used_ext;
    logic [TOT_W-1:0]      wrong_full;

    assign full     = (used_reg == CNT_W'(MAX_LABELS));
    assign rd_fire  = cmd.rd_issue && (idx_reg < used_reg);
    assign acc_fire = cmd.accumulate && pend_reg;
    assign take     = !found_reg || (rd_count_reg > best_cnt_reg) ||
                      ((rd_count_reg == best_cnt_reg) && (rd_label_reg < best_lab_reg));
    assign pl_ext   = PEXT_W'(hit.particle_label);

    assign status.match    = pend_reg && (rd_label_reg == label_reg);
    assign status.scan_end = (idx_reg == used_reg) && !pend_reg;

    // One write port: bump a matched count, or append a new label
    always_comb
    begin
        wr_en = cmd.hit_write || (cmd.miss_write && !full);
        if (cmd.hit_write)
        begin
            wr_addr  = rd_addr_reg;
            wr_count = (rd_count_reg == COUNT_MAX) ? rd_count_reg :
                       rd_count_reg + COUNT_BITS'(1);
        end
        else
        begin
            wr_addr  = used_reg[IDX_W-1:0];
            wr_count = COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[wr_addr] <= label_reg;
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_fire)
        begin
            rd_label_reg <= label_mem[idx_reg[IDX_W-1:0]];
            rd_count_reg <= count_mem[idx_reg[IDX_W-1:0]];
            rd_addr_reg  <= idx_reg[IDX_W-1:0];
        end
    end

    // Result of the finished search
    always_comb
    begin
        lab_ext    = LEXT_W'(best_lab_reg);
        cnt_ext    = CEXT_W'(best_cnt_reg);
        used_ext   = DEXT_W'(used_reg);
        wrong_full = total_reg - TOT_W'(best_cnt_reg);

        result_next.best_label = found_reg ? lab_ext[tmlm_pkg::BEST_LABEL_W-1:0] :
                                 tmlm_pkg::NO_LABEL;
        result_next.true_hits  = cnt_ext[tmlm_pkg::TALLY_W-1:0];
        result_next.wrong_hits = (wrong_full > TOT_W'(tmlm_pkg::TALLY_MAX)) ?
                                 tmlm_pkg::TALLY_MAX : wrong_full[tmlm_pkg::TALLY_W-1:0];
        result_next.fake_hits  = fake_reg;
        result_next.distinct_labels = (used_ext > DEXT_W'(tmlm_pkg::DISTINCT_MAX)) ?
                                      tmlm_pkg::DISTINCT_MAX :
                                      used_ext[tmlm_pkg::DISTINCT_W-1:0];
        result_next.label_overflow = ovf_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            label_reg <= pl_ext[LABEL_BITS-1:0];
        end
        if (cmd.scan_start)
        begin
            best_cnt_reg <= '0;
            best_lab_reg <= '0;
            total_reg    <= TOT_W'(drop_reg);
        end
        else if (acc_fire)
        begin
            total_reg <= total_reg + TOT_W'(rd_count_reg);
            if (take)
            begin
                best_cnt_reg <= rd_count_reg;
                best_lab_reg <= rd_label_reg;
            end
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fake_reg  <= '0;
            drop_reg  <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;

            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= rd_fire;
                if (rd_fire)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (acc_fire)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.fake_inc && (fake_reg != tmlm_pkg::TALLY_MAX))
            begin
                fake_reg <= fake_reg + tmlm_pkg::TALLY_W'(1);
            end

            if (cmd.miss_write)
            begin
                if (!full)
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                    if (drop_reg != tmlm_pkg::TALLY_MAX)
                    begin
                        drop_reg <= drop_reg + tmlm_pkg::TALLY_W'(1);
                    end
                end
            end

            if (cmd.emit)
            begin
                used_reg <= '0;
                fake_reg <= '0;
                drop_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/track_majority_label_matcher.sv]
// Top level of the track majority label matcher: sequencer plus table datapath.
//
// Feed the hits of one track as transactions (start high while busy is low),
// then one end-of-track transaction. Each labelled hit walks the label table
// through its single memory read port, one entry per cycle. A new label keeps
// busy high while all N entries are read, where N is the number of distinct
// labels held so far; for a label already held, the walk stops at the match.
// Fake hits and ignored hits never raise busy. The end-of-track transaction
// walks all N entries to find the winner, with busy high for the walk. Its
// result is registered on result and flagged by done, which is high for a
// single cycle: the first cycle that busy is low again. The receiver cannot
// stall: sample result whenever done is high. Table contents need no clearing
// after reset, since only entries below the fill count are ever read.
module track_majority_label_matcher
#(
    parameter int MAX_LABELS = tmlm_pkg::DEF_MAX_LABELS,
    parameter int COUNT_BITS = tmlm_pkg::DEF_COUNT_BITS,
    parameter int LABEL_BITS = tmlm_pkg::DEF_LABEL_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tmlm_pkg::hit_t    hit,
    output logic              done,
    output tmlm_pkg::result_t result
);

    // Command and status between sequencer and datapath
    tmlm_pkg::ctrl_cmd_t    cmd;
    tmlm_pkg::ctrl_status_t status;

    // Sequencer: accept a transaction, drive the table walk
    tmlm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .hit    (hit),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: hold the table and tallies, search, register the result
    tmlm_datapath
    #(
        .MAX_LABELS (MAX_LABELS),
        .COUNT_BITS (COUNT_BITS),
        .LABEL_BITS (LABEL_BITS)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

[tb/track_majority_label_matcher_test.sv]
// Self-checking testbench for the track majority label matcher.
`timescale 1ns / 1ps

module track_majority_label_matcher_test;

    import tmlm_pkg::*;

    localparam int          TABLE_DEPTH = DEF_MAX_LABELS;
    localparam int unsigned COUNT_TOP   = (1 << DEF_COUNT_BITS) - 1;
    localparam int unsigned TALLY_TOP   = 255;
    localparam int          SCAN_SLACK  = DEF_MAX_LABELS + 16;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          PHASE_ITEMS = 120;

    // One entry of the stimulus queue. A pause entry carries no transaction:
    // it holds the driver until every outstanding result has come back.
    typedef struct {
        hit_t        item;
        bit          pause;
        int unsigned gap_pct;
    } stim_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    hit_t    hit   = '0;
    logic    busy;
    logic    done;
    result_t result;

    stim_t   hit_queue[$];
    result_t want_results[$];

    // Track state of the predictor: label table, per-label counts and tallies
    logic [PARTICLE_LABEL_W-1:0] seen_label [TABLE_DEPTH];
    int unsigned                 seen_count [TABLE_DEPTH];
    int unsigned                 labels_held   = 0;
    int unsigned                 fake_count    = 0;
    int unsigned                 dropped_count = 0;
    bit                          table_full    = 1'b0;

    bit          took        = 1'b0;   // transaction accepted at the last rising edge
    int unsigned cur_gap_pct = 19;
    int unsigned live_items  = 0;      // queued items that the block does not ignore
    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;
    int unsigned checked     = 0;
    int unsigned empty_seen  = 0;
    int unsigned ovf_seen    = 0;
    int unsigned sat_seen    = 0;

    track_majority_label_matcher uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .hit    (hit),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: fold one accepted transaction into the track state. An
    // end-of-track transaction computes the expected result and clears.
    // ------------------------------------------------------------------
    task automatic absorb_hit(input hit_t h);
        int unsigned total;
        int unsigned win_count;
        int unsigned wrong;
        logic [PARTICLE_LABEL_W-1:0] win_label;
        bit found;
        bit matched;
        result_t r;
        begin
            total = 0;
            win_count = 0;
            wrong = 0;
            win_label = '0;
            found = 1'b0;
            matched = 1'b0;
            if (h.action == ACTION_HIT)
            begin
                if (h.hit_kind == KIND_LABEL)
                begin
                    // Search the table; bump a known label or append a new one
                    for (int i = 0; i < labels_held; i++)
                    begin
                        if (!matched && seen_label[i] == h.particle_label)
                        begin
                            matched = 1'b1;
                            if (seen_count[i] < COUNT_TOP)
                                seen_count[i]++;
                        end
                    end
                    if (!matched)
                    begin
                        if (labels_held < TABLE_DEPTH)
                        begin
                            seen_label[labels_held] = h.particle_label;
                            seen_count[labels_held] = 1;
                            labels_held++;
                        end
                        else
                        begin
                            // Table full: drop the label but count the hit as wrong
                            table_full = 1'b1;
                            if (dropped_count < TALLY_TOP)
                                dropped_count++;
                        end
                    end
                end
                else if (h.hit_kind == KIND_FAKE)
                begin
                    if (fake_count < TALLY_TOP)
                        fake_count++;
                end
                // Any other kind carries no usable reference: drop it
            end
            else
            begin
                // Walk the table for the largest count, smallest label on a tie
                total = dropped_count;
                for (int i = 0; i < labels_held; i++)
                begin
                    total += seen_count[i];
                    if (!found || seen_count[i] > win_count ||
                        (seen_count[i] == win_count && seen_label[i] < win_label))
                    begin
                        found = 1'b1;
                        win_count = seen_count[i];
                        win_label = seen_label[i];
                    end
                end
                wrong = total - win_count;
                if (wrong > TALLY_TOP)
                    wrong = TALLY_TOP;
                r.best_label      = found ? $signed({1'b0, win_label}) : NO_LABEL;
                r.true_hits       = TALLY_W'(win_count);
                r.wrong_hits      = TALLY_W'(wrong);
                r.fake_hits       = TALLY_W'(fake_count);
                r.distinct_labels = DISTINCT_W'(labels_held);
                r.label_overflow  = table_full;
                want_results.push_back(r);
                if (!found)
                    empty_seen++;
                if (table_full)
                    ovf_seen++;
                if (win_count == COUNT_TOP || wrong == TALLY_TOP || fake_count == TALLY_TOP)
                    sat_seen++;
                labels_held   = 0;
                fake_count    = 0;
                dropped_count = 0;
                table_full    = 1'b0;
            end
        end
    endtask

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Compare one result transaction, field by field, against the oldest expectation
    task automatic check_result(input result_t got);
        result_t want;
        begin
            if (want_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                err_count++;
            end
            else
            begin
                want = want_results.pop_front();
                checked++;
                if (got.best_label !== want.best_label)
                    report_field("best_label", want.best_label, got.best_label);
                if (got.true_hits !== want.true_hits)
                    report_field("true_hits", want.true_hits, got.true_hits);
                if (got.wrong_hits !== want.wrong_hits)
                    report_field("wrong_hits", want.wrong_hits, got.wrong_hits);
                if (got.fake_hits !== want.fake_hits)
                    report_field("fake_hits", want.fake_hits, got.fake_hits);
                if (got.distinct_labels !== want.distinct_labels)
                    report_field("distinct_labels", want.distinct_labels,
                                 got.distinct_labels);
                if (got.label_overflow !== want.label_overflow)
                    report_field("label_overflow", want.label_overflow,
                                 got.label_overflow);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check a finished result first,
    // then record the transaction accepted at this edge, if any.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        took = 1'b0;
        if (rst_n)
        begin
            if (done === 1'b1)
                check_result(result);
            if (start && !busy)
            begin
                took = 1'b1;
                absorb_hit(hit);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold a transaction until
    // it is accepted, then advance to the next queue entry or idle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        stim_t nxt;
        logic  go;
        go = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !took)
        begin
            go = 1'b1;   // hold the current transaction
        end
        else if (hit_queue.size() != 0)
        begin
            if (hit_queue[0].pause)
            begin
                // Release the pause only once nothing is outstanding
                if (want_results.size() == 0)
                    void'(hit_queue.pop_front());
            end
            else if ($urandom_range(99) >= hit_queue[0].gap_pct)
            begin
                nxt = hit_queue.pop_front();
                hit <= nxt.item;
                go = 1'b1;
            end
        end
        if (rst_n)
            start <= go;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_raw(input logic act, input logic [1:0] kind,
                             input logic [PARTICLE_LABEL_W-1:0] lab);
        stim_t s;
        begin
            s.item.action         = act;
            s.item.hit_kind       = kind;
            s.item.particle_label = lab;
            s.pause               = 1'b0;
            s.gap_pct             = cur_gap_pct;
            hit_queue.push_back(s);
            if (act == ACTION_END || kind == KIND_LABEL || kind == KIND_FAKE)
                live_items++;
        end
    endtask

    task automatic queue_hit(input logic [1:0] kind, input logic [PARTICLE_LABEL_W-1:0] lab);
        queue_raw(ACTION_HIT, kind, lab);
    endtask

    // The end-of-track transaction carries junk in its hit fields on purpose
    task automatic queue_end();
        queue_raw(ACTION_END, 2'($urandom_range(3)), PARTICLE_LABEL_W'($urandom));
    endtask

    task automatic queue_pause();
        stim_t s;
        begin
            s.item    = '0;
            s.pause   = 1'b1;
            s.gap_pct = 0;
            hit_queue.push_back(s);
        end
    endtask

    // Ordinary track: a few labels, some of them extreme or one bit apart,
    // mixed with fake and ignored hits
    task automatic queue_mixed_track();
        logic [PARTICLE_LABEL_W-1:0] pool [6];
        int unsigned pool_n;
        int unsigned len;
        int unsigned roll;
        begin
            pool_n = $urandom_range(1, 6);
            len = $urandom_range(0, 24);
            for (int p = 0; p < 6; p++)
            begin
                roll = $urandom_range(3);
                if (roll == 0)
                    pool[p] = $urandom_range(1) ? '1 : '0;
                else if (roll == 1 && p > 0)
                    pool[p] = pool[0] ^ (PARTICLE_LABEL_W'(1) << $urandom_range(23));
                else
                    pool[p] = PARTICLE_LABEL_W'($urandom);
            end
            for (int i = 0; i < len; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    // Skew toward the low pool entries so ties and clear winners both occur
                    queue_hit(KIND_LABEL, pool[$urandom_range($urandom_range(pool_n - 1))]);
                else if (roll < 85)
                    queue_hit(KIND_FAKE, PARTICLE_LABEL_W'($urandom));
                else if (roll < 95)
                    queue_hit(2'd2, PARTICLE_LABEL_W'($urandom));
                else
                    queue_hit(2'd3, PARTICLE_LABEL_W'($urandom));
            end
            queue_end();
        end
    endtask

    // Fill the table past its depth, then revisit held and dropped labels
    task automatic queue_overflow_track();
        logic [PARTICLE_LABEL_W-1:0] base;
        logic [PARTICLE_LABEL_W-1:0] stride;
        int unsigned n_new;
        begin
            base   = PARTICLE_LABEL_W'($urandom);
            stride = PARTICLE_LABEL_W'($urandom) | PARTICLE_LABEL_W'(1);
            n_new  = TABLE_DEPTH + $urandom_range(1, 8);
            for (int i = 0; i < n_new; i++)
                queue_hit(KIND_LABEL, base + PARTICLE_LABEL_W'(i) * stride);
            for (int i = 0; i < 12; i++)
            begin
                if ($urandom_range(3) == 0)
                    queue_hit(KIND_FAKE, PARTICLE_LABEL_W'($urandom));
                else
                    queue_hit(KIND_LABEL,
                              base + PARTICLE_LABEL_W'($urandom_range(n_new - 1)) * stride);
            end
            queue_end();
        end
    endtask

    // Drive two labels into count saturation (tie at the top, smaller wins),
    // push the wrong tally past its limit and saturate the fake tally
    task automatic queue_heavy_track();
        logic [PARTICLE_LABEL_W-1:0] lab_a;
        int unsigned left_a, left_b, left_c, left_f, pick;
        begin
            lab_a  = PARTICLE_LABEL_W'($urandom);
            left_a = COUNT_TOP + 2;
            left_b = COUNT_TOP + 2;
            left_c = 3;
            left_f = TALLY_TOP + 1;
            while (left_a + left_b + left_c + left_f != 0)
            begin
                pick = $urandom_range(left_a + left_b + left_c + left_f - 1);
                if (pick < left_a)
                begin
                    queue_hit(KIND_LABEL, lab_a);
                    left_a--;
                end
                else if (pick < left_a + left_b)
                begin
                    queue_hit(KIND_LABEL, lab_a ^ 24'h000001);
                    left_b--;
                end
                else if (pick < left_a + left_b + left_c)
                begin
                    queue_hit(KIND_LABEL, ~lab_a);
                    left_c--;
                end
                else
                begin
                    queue_hit(KIND_FAKE, lab_a);
                    left_f--;
                end
            end
            queue_end();
        end
    endtask

    // Mostly well-formed tracks, with a little noise of raw random transactions;
    // add about count live items beyond the heavy track, if any
    task automatic queue_random_phase(input int unsigned count, input bit with_heavy);
        int unsigned roll;
        int unsigned target;
        begin
            if (with_heavy)
                queue_heavy_track();
            target = live_items + count;
            while (live_items < target)
            begin
                roll = $urandom_range(99);
                if (roll < 84)
                    queue_mixed_track();
                else if (roll < 88)
                    queue_overflow_track();
                else
                    queue_raw($urandom_range(3) == 0 ? ACTION_END : ACTION_HIT,
                              2'($urandom_range(3)), PARTICLE_LABEL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        // Directed part: empty track with junk on the end transaction
        cur_gap_pct = 19;
        queue_raw(ACTION_END, 2'd3, '1);
        // Only fake and ignored hits: no winner, one fake
        queue_hit(KIND_FAKE, '0);
        queue_hit(2'd2, '1);
        queue_hit(2'd3, 24'h000007);
        queue_end();
        // Extreme labels tied at two hits each: the smaller label wins
        queue_hit(KIND_LABEL, '1);
        queue_hit(KIND_LABEL, '0);
        queue_hit(KIND_LABEL, '1);
        queue_hit(KIND_LABEL, '0);
        queue_hit(KIND_FAKE, 24'h123456);
        queue_raw(ACTION_END, KIND_LABEL, 24'h000123);
        // Clear winner among alternating bit patterns
        queue_hit(KIND_LABEL, 24'h0ABCDE);
        queue_hit(KIND_LABEL, 24'h555555);
        queue_hit(KIND_LABEL, 24'hAAAAAA);
        queue_hit(KIND_LABEL, 24'hAAAAAA);
        queue_raw(ACTION_END, KIND_FAKE, 24'hFFFFFF);
        // Back-to-back end transactions: the second sees a cleared track
        queue_hit(KIND_LABEL, 24'h800000);
        queue_end();
        queue_end();
        queue_pause();

        // Random part in three idling regimes, settling between them
        queue_random_phase(PHASE_ITEMS, 1'b1);
        queue_pause();
        cur_gap_pct = 63;
        queue_random_phase(PHASE_ITEMS, 1'b0);
        queue_pause();
        cur_gap_pct = 0;
        queue_random_phase(PHASE_ITEMS, 1'b0);

        // Hold reset, then release it away from the rising edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until the last transaction is accepted and its walk is over,
        // then for the last result
        do
            @(posedge clk);
        while (hit_queue.size() != 0 || start || busy);
        while (want_results.size() != 0)
            @(negedge clk);
        // Leave room for a full table walk so any stray result is caught
        repeat (SCAN_SLACK) @(negedge clk);

        $display("Ran %0d hit and end-of-track transactions, checked %0d track results.",
                 live_items, checked);
        $display("Results covered %0d empty tracks, %0d table overflows, %0d saturated tallies.",
                 empty_seen, ovf_seen, sat_seen);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
